FILE: hdl/rlhm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rlhm_pkg
// Shared types and constants of the lifecycle and health monitor.
// ============================================================================
package rlhm_pkg;

    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int NUM_COUNTERS      = 6;

    localparam int CNT_ACCEPTED     = 0;
    localparam int CNT_MATCHED      = 1;
    localparam int CNT_PUBLISHED    = 2;
    localparam int CNT_BACKPRESSURE = 3;
    localparam int CNT_CAPACITY     = 4;
    localparam int CNT_FAILURE      = 5;

    localparam logic [2:0] FUNC_START          = 3'd0;
    localparam logic [2:0] FUNC_BEGIN_SHUTDOWN = 3'd1;
    localparam logic [2:0] FUNC_END_SHUTDOWN   = 3'd2;
    localparam logic [2:0] FUNC_INGRESS        = 3'd3;
    localparam logic [2:0] FUNC_MATCHING       = 3'd4;
    localparam logic [2:0] FUNC_PUBLICATION    = 3'd5;

    localparam logic [3:0] ING_PROGRESS      = 4'd0;
    localparam logic [3:0] ING_BACKPRESSURE  = 4'd1;
    localparam logic [3:0] ING_JOURNAL_FULL  = 4'd2;
    localparam logic [3:0] ING_SEQ_EXHAUSTED = 4'd3;
    localparam logic [3:0] ING_PERSIST_FAIL  = 4'd4;
    localparam logic [3:0] ING_COMMIT_INDET  = 4'd5;
    localparam logic [3:0] ING_RECOVERY_REQ  = 4'd6;
    localparam logic [3:0] ING_BAD_PAYLOAD   = 4'd7;
    localparam logic [3:0] ING_TIME_BACKWARD = 4'd8;
    localparam logic [3:0] ING_POISONED      = 4'd9;

    localparam logic [3:0] MAT_PROGRESS      = 4'd0;
    localparam logic [3:0] MAT_INPUT_EMPTY   = 4'd1;
    localparam logic [3:0] MAT_BACKPRESSURE  = 4'd2;
    localparam logic [3:0] MAT_SEQ_EXHAUSTED = 4'd3;
    localparam logic [3:0] MAT_NO_CAPACITY   = 4'd4;
    localparam logic [3:0] MAT_BAD_COMMAND   = 4'd5;
    localparam logic [3:0] MAT_BAD_SEQUENCE  = 4'd6;
    localparam logic [3:0] MAT_TIME_BACKWARD = 4'd7;
    localparam logic [3:0] MAT_INVARIANT     = 4'd8;
    localparam logic [3:0] MAT_POISONED      = 4'd9;

    localparam logic [3:0] PUB_PROGRESS      = 4'd0;

    typedef enum logic [2:0] {
        LC_STARTING = 3'd0,
        LC_RUNNING  = 3'd1,
        LC_DRAINING = 3'd2,
        LC_STOPPED  = 3'd3,
        LC_FAILED   = 3'd4
    } t_lifecycle;

    typedef enum logic [2:0] {
        H_HEALTHY       = 3'd0,
        H_BACKPRESSURED = 3'd1,
        H_CAPACITY      = 3'd2,
        H_RECOVERY      = 3'd3,
        H_CORRUPTION    = 3'd4
    } t_health;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] status_code;
        logic       cmdq_empty;
        logic       evq_empty;
    } t_item;

    typedef struct packed {
        logic                    accepted;
        t_lifecycle              lifecycle;
        t_health                 health;
        logic [NUM_COUNTERS-1:0] bump;
    } t_effect;

endpackage

FILE: hdl/rlhm_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rlhm_if
// Valid/ready channels of the monitor: command/report input and result output.
// ============================================================================
interface rlhm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [3:0] status_code;
    logic       cmdq_empty;
    logic       evq_empty;

    modport source (output valid, func, status_code, cmdq_empty,
                    evq_empty, input ready);
    modport sink   (input valid, func, status_code, cmdq_empty,
                    evq_empty, output ready);
endinterface

interface rlhm_out_if #(
    parameter int COUNTER_WIDTH = 64
);
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic [2:0]               lifecycle_now;
    logic [2:0]               health_now;
    logic [COUNTER_WIDTH-1:0] accepted_count;
    logic [COUNTER_WIDTH-1:0] matched_count;
    logic [COUNTER_WIDTH-1:0] published_count;
    logic [COUNTER_WIDTH-1:0] backpressure_count;
    logic [COUNTER_WIDTH-1:0] capacity_count;
    logic [COUNTER_WIDTH-1:0] failure_count;

    modport source (output valid, accepted, lifecycle_now, health_now, accepted_count,
                    matched_count, published_count, backpressure_count,
                    capacity_count, failure_count, input ready);
    modport sink   (input valid, accepted, lifecycle_now, health_now, accepted_count,
                    matched_count, published_count, backpressure_count,
                    capacity_count, failure_count, output ready);
endinterface

FILE: hdl/runtime_lifecycle_health_monitor_top.sv
`timescale 1ns / 1ps
// ============================================================================
// runtime_lifecycle_health_monitor_top
// Lifecycle and health monitor: commands and status reports in, one result
// per beat out.
// ============================================================================
// Takes one command or status report per cycle unless the output stalls, and
// returns one result beat for each via the input and result registers. A beat
// is held in an input register, then decoded against the lifecycle, health and
// counter registers, which update in that same cycle; those state registers
// drive the result payload directly, so the next beat is decoded only once the
// pending result has been taken (or is taken in that cycle). Counters are
// COUNTER_WIDTH bits wide and saturate at all ones; health never decreases.
module runtime_lifecycle_health_monitor_top #(
    parameter int COUNTER_WIDTH = rlhm_pkg::COUNTER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlhm_in_if.sink           i_in,
    rlhm_out_if.source        o_out
);
    import rlhm_pkg::*;

    logic                     r_s1_valid;
    t_item                    r_s1_item;
    logic                     r_out_valid;
    logic                     r_accepted;
    t_lifecycle               r_lifecycle;
    t_health                  r_health;
    t_effect                  effect;
    logic                     s1_advance;
    logic [COUNTER_WIDTH-1:0] count [NUM_COUNTERS];

    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_item.func        <= i_in.func;
            r_s1_item.status_code <= i_in.status_code;
            r_s1_item.cmdq_empty  <= i_in.cmdq_empty;
            r_s1_item.evq_empty   <= i_in.evq_empty;
        end
    end

    rlhm_decode u_decode (
        .i_item      (r_s1_item),
        .i_lifecycle (r_lifecycle),
        .i_health    (r_health),
        .o_effect    (effect)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_lifecycle <= LC_STARTING;
            r_health    <= H_HEALTHY;
            r_accepted  <= 1'b0;
        end else begin
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_lifecycle <= effect.lifecycle;
                r_health    <= effect.health;
                r_accepted  <= effect.accepted;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    rlhm_counter_bank #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_advance),
        .i_bump  (effect.bump),
        .o_count (count)
    );

    assign o_out.valid              = r_out_valid;
    assign o_out.accepted           = r_accepted;
    assign o_out.lifecycle_now      = r_lifecycle;
    assign o_out.health_now         = r_health;
    assign o_out.accepted_count     = count[CNT_ACCEPTED];
    assign o_out.matched_count      = count[CNT_MATCHED];
    assign o_out.published_count    = count[CNT_PUBLISHED];
    assign o_out.backpressure_count = count[CNT_BACKPRESSURE];
    assign o_out.capacity_count     = count[CNT_CAPACITY];
    assign o_out.failure_count      = count[CNT_FAILURE];

    a_health_mono: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_health >= $past(r_health)))
        else $error("health level decreased");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lifecycle == LC_FAILED) |=> (r_lifecycle == LC_FAILED))
        else $error("left the failed state");

    a_stopped_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lifecycle == LC_STOPPED) |=>
            (r_lifecycle == LC_STOPPED || r_lifecycle == LC_FAILED))
        else $error("stopped left other than to failed");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_advance |=> $stable(r_lifecycle) && $stable(r_health))
        else $error("state changed without a processed beat");

endmodule

FILE: hdl/rlhm_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// rlhm_decode
// Decodes one command or status report against the current lifecycle and
// health: next lifecycle, next health, accept flag and counter bump mask.
// ============================================================================
module rlhm_decode (
    input  rlhm_pkg::t_item      i_item,
    input  rlhm_pkg::t_lifecycle i_lifecycle,
    input  rlhm_pkg::t_health    i_health,
    output rlhm_pkg::t_effect    o_effect
);
    import rlhm_pkg::*;

    t_health    lift_lvl;
    logic       lift_en;
    logic       fail_en;

    always_comb begin
        o_effect           = '0;
        o_effect.lifecycle = i_lifecycle;
        lift_lvl           = H_HEALTHY;
        lift_en            = 1'b0;
        fail_en            = 1'b0;

        case (i_item.func)
            FUNC_START: begin
                if (i_lifecycle == LC_STARTING) begin
                    o_effect.lifecycle = LC_RUNNING;
                    o_effect.accepted  = 1'b1;
                end
            end
            FUNC_BEGIN_SHUTDOWN: begin
                if (i_lifecycle == LC_RUNNING) begin
                    o_effect.lifecycle = LC_DRAINING;
                    o_effect.accepted  = 1'b1;
                end
            end
            FUNC_END_SHUTDOWN: begin
                if (i_lifecycle == LC_DRAINING && i_item.cmdq_empty
                        && i_item.evq_empty) begin
                    o_effect.lifecycle = LC_STOPPED;
                    o_effect.accepted  = 1'b1;
                end
            end
            FUNC_INGRESS: begin
                case (i_item.status_code)
                    ING_PROGRESS: o_effect.bump[CNT_ACCEPTED] = 1'b1;
                    ING_BACKPRESSURE: begin
                        lift_en = 1'b1;
                        lift_lvl = H_BACKPRESSURED;
                        o_effect.bump[CNT_BACKPRESSURE] = 1'b1;
                    end
                    ING_JOURNAL_FULL, ING_SEQ_EXHAUSTED: begin
                        lift_en = 1'b1;
                        lift_lvl = H_CAPACITY;
                        o_effect.bump[CNT_CAPACITY] = 1'b1;
                    end
                    ING_PERSIST_FAIL, ING_COMMIT_INDET, ING_RECOVERY_REQ: begin
                        fail_en = 1'b1;
                        lift_en = 1'b1;
                        lift_lvl = H_RECOVERY;
                    end
                    ING_BAD_PAYLOAD, ING_TIME_BACKWARD: o_effect.bump[CNT_FAILURE] = 1'b1;
                    ING_POISONED: begin
                        fail_en = 1'b1;
                        lift_en = 1'b1;
                        lift_lvl = H_CORRUPTION;
                    end
                    default: ;
                endcase
            end
            FUNC_MATCHING: begin
                case (i_item.status_code)
                    MAT_PROGRESS: o_effect.bump[CNT_MATCHED] = 1'b1;
                    MAT_INPUT_EMPTY: ;
                    MAT_BACKPRESSURE: begin
                        lift_en = 1'b1;
                        lift_lvl = H_BACKPRESSURED;
                        o_effect.bump[CNT_BACKPRESSURE] = 1'b1;
                    end
                    MAT_SEQ_EXHAUSTED, MAT_NO_CAPACITY: begin
                        lift_en = 1'b1;
                        lift_lvl = H_CAPACITY;
                        o_effect.bump[CNT_CAPACITY] = 1'b1;
                    end
                    MAT_BAD_COMMAND, MAT_BAD_SEQUENCE, MAT_TIME_BACKWARD,
                    MAT_INVARIANT, MAT_POISONED: begin
                        fail_en = 1'b1;
                        lift_en = 1'b1;
                        lift_lvl = H_CORRUPTION;
                    end
                    default: ;
                endcase
            end
            FUNC_PUBLICATION: begin
                if (i_item.status_code == PUB_PROGRESS) begin
                    o_effect.bump[CNT_PUBLISHED] = 1'b1;
                end
            end
            default: ;
        endcase

        if (fail_en) begin
            o_effect.lifecycle = LC_FAILED;
            o_effect.bump[CNT_FAILURE] = 1'b1;
        end

        // health only ever rises
        if (lift_en && (lift_lvl > i_health)) begin
            o_effect.health = lift_lvl;
        end else begin
            o_effect.health = i_health;
        end
    end

endmodule

FILE: hdl/rlhm_counter_bank.sv
`timescale 1ns / 1ps
// ============================================================================
// rlhm_counter_bank
// Six saturating event counters, bumped by mask on each processed beat.
// ============================================================================
module rlhm_counter_bank #(
    parameter int COUNTER_WIDTH = rlhm_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [rlhm_pkg::NUM_COUNTERS-1:0] i_bump,
    output logic [COUNTER_WIDTH-1:0]          o_count [rlhm_pkg::NUM_COUNTERS]
);
    import rlhm_pkg::*;

    logic [COUNTER_WIDTH-1:0] r_cnt [NUM_COUNTERS];

    for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_cnt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[g] <= '0;
            end else if (i_en && i_bump[g] && (r_cnt[g] != '1)) begin
                r_cnt[g] <= r_cnt[g] + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
            end
        end
        assign o_count[g] = r_cnt[g];
    end

    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[CNT_FAILURE] == '1) |=> (r_cnt[CNT_FAILURE] == '1))
        else $error("failure counter left saturation");

    a_step_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_cnt[CNT_ACCEPTED]) && $stable(r_cnt[CNT_CAPACITY]))
        else $error("counter moved without a processed beat");

    a_no_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_bump[CNT_MATCHED]) |=> $stable(r_cnt[CNT_MATCHED]))
        else $error("matched counter moved without a bump");

endmodule
